// File: rtl/core/dpbs_pkg.sv
// Shared types and constants for the pop-both-sum double-ended queue.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package dpbs_pkg;

    // Default ring store depth and command queue depth
    localparam int DEPTH_DEF  = 1024;
    localparam int CMDQ_DEPTH = 4;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_SUM    = 2'd2
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command kinds passed from front end to back end
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_POP    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    // Command control part; ring addresses travel beside it
    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [31:0] value;
    } t_cmd_ctl;

endpackage

`default_nettype wire

// File: rtl/core/deque_pop_both_sum_top.sv
// Double-ended queue with pop-both-sum. One operation accepted per cycle while
// the command queue is not full, sustained while results are popped, as set by
// the single-write, two-read ring store port. Each result passes the command
// queue, the registered store read and the sum register. Synchronous active-low
// reset empties the deque, the command queue and the output register; the ring
// store has no clearing pass. Depends on dpbs_pkg.
`default_nettype none

module deque_pop_both_sum_top #(
    parameter int DEPTH = dpbs_pkg::DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [31:0] i_value,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              o_status,
    output logic signed [32:0]      o_sum
);

    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(dpbs_pkg::t_cmd_ctl) + 2 * AW;

    dpbs_pkg::t_cmd_ctl fe_ctl, be_ctl;
    logic [AW-1:0]      fe_addr_a, fe_addr_b, be_addr_a, be_addr_b;
    logic               fe_push, q_vld, q_pop;
    logic [QW-1:0]      q_out;

    // Front end: pointer bookkeeping
    dpbs_front #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .o_cmd_ctl  (fe_ctl),
        .o_addr_a   (fe_addr_a),
        .o_addr_b   (fe_addr_b),
        .o_cmd_push (fe_push)
    );

    // Command queue between the two sides
    dpbs_cmdq #(
        .W (QW)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_ctl, fe_addr_a, fe_addr_b}),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign {be_ctl, be_addr_a, be_addr_b} = q_out;

    // Back end: store access and sum
    dpbs_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd_ctl (be_ctl),
        .i_addr_a  (be_addr_a),
        .i_addr_b  (be_addr_b),
        .o_cmd_pop (q_pop),
        .o_empty   (empty),
        .o_status  (o_status),
        .o_sum     (o_sum),
        .i_pop     (pop)
    );

endmodule

`default_nettype wire

// File: rtl/core/dpbs_front.sv
// Front end: accepts operations, keeps head, tail and entry count, and
// turns each defined operation into a store write, a pop read or a status command.
// Depends on dpbs_pkg.
`default_nettype none

module dpbs_front #(
    parameter int DEPTH = dpbs_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [31:0]        i_value,
    output dpbs_pkg::t_cmd_ctl      o_cmd_ctl,
    output logic [AW-1:0]           o_addr_a,
    output logic [AW-1:0]           o_addr_b,
    output logic                    o_cmd_push
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] head_prev, head_next, tail_prev, tail_next;
    logic          is_full, is_empty;

    // Ring neighbors with wrap at the last index
    always_comb begin
        head_prev = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
        head_next = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
        tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);
        tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
        is_full   = (r_count == CW'(DEPTH));
        is_empty  = (r_count == '0);
    end

    // Classify the operation and update pointers
    always_comb begin
        n_head           = r_head;
        n_tail           = r_tail;
        n_count          = r_count;
        o_cmd_push       = 1'b0;
        o_cmd_ctl.kind   = dpbs_pkg::KIND_STATUS;
        o_cmd_ctl.status = dpbs_pkg::ST_OK;
        o_cmd_ctl.value  = i_value;
        o_addr_a         = r_head;
        o_addr_b         = tail_prev;
        if (i_accept) begin
            case (i_opcode)
                dpbs_pkg::OP_PUSH_FRONT, dpbs_pkg::OP_PUSH_BACK: begin
                    o_cmd_push = 1'b1;
                    if (is_full) begin
                        o_cmd_ctl.kind   = dpbs_pkg::KIND_STATUS;
                        o_cmd_ctl.status = dpbs_pkg::ST_FULL;
                    end else begin
                        o_cmd_ctl.kind = dpbs_pkg::KIND_WRITE;
                        n_count        = r_count + CW'(1);
                        if (i_opcode == dpbs_pkg::OP_PUSH_FRONT) begin
                            n_head   = head_prev;
                            o_addr_a = head_prev;
                        end else begin
                            n_tail   = tail_next;
                            o_addr_a = r_tail;
                        end
                    end
                end
                dpbs_pkg::OP_POP_SUM: begin
                    o_cmd_push = 1'b1;
                    if (is_empty) begin
                        o_cmd_ctl.kind   = dpbs_pkg::KIND_STATUS;
                        o_cmd_ctl.status = dpbs_pkg::ST_EMPTY;
                    end else begin
                        o_cmd_ctl.kind = dpbs_pkg::KIND_POP;
                        n_head         = head_next;
                        // Single entry: drop only the front
                        if (r_count == CW'(1)) begin
                            n_count = '0;
                        end else begin
                            n_tail  = tail_prev;
                            n_count = r_count - CW'(2);
                        end
                    end
                end
                default: begin
                    // Unused code: drop the item
                    o_cmd_push = 1'b0;
                end
            endcase
        end
    end

    // Hold pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dpbs_cmdq.sv
// Short command queue between front end and back end.
// Generic width; depth from dpbs_pkg.
`default_nettype none

module dpbs_cmdq #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_vld,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    localparam int QD  = dpbs_pkg::CMDQ_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);
    localparam logic [QAW-1:0] LAST_SLOT = QAW'(QD - 1);

    logic [W-1:0]   r_slot [QD];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QD));
    assign o_vld   = (r_cnt != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dpbs_back.sv
// Back end: owns the ring store, executes writes, reads both ends for a
// pop, forms the 33-bit sum and holds the result in an output register.
// Depends on dpbs_pkg.
`default_nettype none

module dpbs_back #(
    parameter int DEPTH = dpbs_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_vld,
    input  wire dpbs_pkg::t_cmd_ctl  i_cmd_ctl,
    input  wire logic [AW-1:0]       i_addr_a,
    input  wire logic [AW-1:0]       i_addr_b,
    output logic                     o_cmd_pop,
    output logic                     o_empty,
    output logic [1:0]               o_status,
    output logic signed [32:0]       o_sum,
    input  wire logic                i_pop
);

    logic [31:0]       r_mem [DEPTH];
    logic [31:0]       r_rd_a, r_rd_b;
    logic              r_b_vld, n_b_vld;
    logic              r_b_is_pop;
    dpbs_pkg::t_status r_b_status;
    logic              r_out_vld, n_out_vld;
    logic [1:0]        r_out_status;
    logic signed [32:0] r_out_sum;
    logic              is_write, issue, b_adv;
    logic signed [32:0] sum_full;

    // Write commands retire at once; reads wait for a free read stage
    assign is_write  = i_cmd_vld && (i_cmd_ctl.kind == dpbs_pkg::KIND_WRITE);
    assign b_adv     = r_b_vld && (!r_out_vld || i_pop);
    assign issue     = i_cmd_vld && (i_cmd_ctl.kind != dpbs_pkg::KIND_WRITE)
                       && (!r_b_vld || b_adv);
    assign o_cmd_pop = is_write || issue;

    // Ring store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (is_write) begin
            r_mem[i_addr_a] <= i_cmd_ctl.value;
        end
        if (issue) begin
            r_rd_a <= r_mem[i_addr_a];
            r_rd_b <= r_mem[i_addr_b];
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_is_pop <= (i_cmd_ctl.kind == dpbs_pkg::KIND_POP);
            r_b_status <= i_cmd_ctl.status;
        end
    end

    // Add front and back without wrap
    assign sum_full = $signed({r_rd_a[31], r_rd_a}) + $signed({r_rd_b[31], r_rd_b});

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_status <= r_b_is_pop ? dpbs_pkg::ST_OK : r_b_status;
            r_out_sum    <= r_b_is_pop ? sum_full : '0;
        end
    end

    // Stage valid flags
    always_comb begin
        n_b_vld   = issue ? 1'b1 : (b_adv ? 1'b0 : r_b_vld);
        n_out_vld = b_adv ? 1'b1 : ((i_pop && r_out_vld) ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_b_vld   <= n_b_vld;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_empty  = !r_out_vld;
    assign o_status = r_out_status;
    assign o_sum    = r_out_sum;

endmodule

`default_nettype wire

// File: verif/dpbs_sum_board_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the pop-both-sum deque: mirrors the ring store and queues expected results.
// Depends on dpbs_pkg for the operation and status codes and the default depth.

package dpbs_sum_board_pkg;

    import dpbs_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;

    // One expected result transfer
    typedef struct {
        t_status            status;
        logic signed [32:0] sum;
    } t_sum_result;

    class deque_sum_board;
        logic [31:0]  ring [RING_DEPTH];
        int unsigned  head;
        int unsigned  tail;
        int unsigned  level;
        int unsigned  peak;
        t_sum_result  owed[$];
        int           errors;
        int           n_ops;
        int           n_sums;
        int           n_empty;
        int           n_full;

        function new();
            head    = 0;
            tail    = 0;
            level   = 0;
            peak    = 0;
            errors  = 0;
            n_ops   = 0;
            n_sums  = 0;
            n_empty = 0;
            n_full  = 0;
        endfunction

        // Apply one accepted operation to the mirror and queue what it must produce
        function void note_op(logic [1:0] op, logic [31:0] value);
            t_sum_result r;
            int unsigned back_pos;
            n_ops++;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (level >= RING_DEPTH) begin
                        // drop the value, report full
                        r.status = ST_FULL;
                        r.sum    = '0;
                        owed.insert(owed.size(), r);
                    end else begin
                        if (op == OP_PUSH_FRONT) begin
                            head       = (head == 0) ? RING_DEPTH - 1 : head - 1;
                            ring[head] = value;
                        end else begin
                            ring[tail] = value;
                            tail       = (tail + 1) % RING_DEPTH;
                        end
                        level++;
                        if (level > peak) peak = level;
                    end
                end
                OP_POP_SUM: begin
                    if (level == 0) begin
                        r.status = ST_EMPTY;
                        r.sum    = '0;
                    end else begin
                        // sign-extend both ends to 33 bits so the sum cannot wrap
                        back_pos = (tail == 0) ? RING_DEPTH - 1 : tail - 1;
                        r.status = ST_OK;
                        r.sum    = {ring[head][31], ring[head]}
                                 + {ring[back_pos][31], ring[back_pos]};
                        head     = (head + 1) % RING_DEPTH;
                        level--;
                        // a single entry is both ends: remove it once only
                        if (level != 0) begin
                            tail = back_pos;
                            level--;
                        end
                    end
                    owed.insert(owed.size(), r);
                end
                default: ; // unused opcode: no state change, no result
            endcase
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [1:0] status, logic signed [32:0] sum);
            t_sum_result r;
            if (owed.size() == 0) begin
                $error("unexpected result: status %0d sum %0d", status, sum);
                errors++;
                return;
            end
            r = owed[0];
            owed.delete(0);
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                errors++;
            end
            if (sum !== r.sum) begin
                $error("sum: expected %0d, actual %0d", r.sum, sum);
                errors++;
            end
            case (r.status)
                ST_OK:    n_sums++;
                ST_EMPTY: n_empty++;
                default:  n_full++;
            endcase
        endfunction

        function int owed_count();
            return owed.size();
        endfunction

        // Flag every expectation that never showed up
        function void close_out();
            if (owed.size() != 0) begin
                $error("%0d expected results never arrived", owed.size());
                errors += owed.size();
            end
        endfunction
    endclass

endpackage

// File: verif/tb_deque_pop_both_sum_top.sv
`timescale 1ns / 100ps
// Testbench for deque_pop_both_sum_top: directed and random operations, checked by a scoreboard.
// Depends on dpbs_pkg and dpbs_sum_board_pkg.

module tb_deque_pop_both_sum_top;

    import dpbs_pkg::*;
    import dpbs_sum_board_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 11;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          MIXED_ITEMS    = 150;
    localparam int          FULL_EXTRA     = 12;
    localparam int          CLOSING_ITEMS  = 200;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [31:0] W_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN          = 32'h8000_0000;
    localparam logic [31:0] W_NEG1         = 32'hFFFF_FFFF;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_value;
    logic               empty;
    logic               pop;
    logic [1:0]         o_status;
    logic signed [32:0] o_sum;

    deque_sum_board board;
    bit             send_gaps;
    bit             pop_gaps;
    int unsigned    level_guess;
    int             idle_cycles;

    deque_pop_both_sum_top #(
        .DEPTH(DEPTH_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_opcode(i_opcode),
        .i_value (i_value),
        .empty   (empty),
        .pop     (pop),
        .o_status(o_status),
        .o_sum   (o_sum)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Sample both handshakes, feed the scoreboard, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) board.note_op(i_opcode, i_value);
            if (pop && !empty) board.check_result(o_status, o_sum);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("deque_pop_both_sum_top test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Favor the word extremes now and then so the sum hits both ends of its range
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return W_NEG1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Present one operation and hold it until the transfer
    task automatic send_op(input logic [1:0] op, input logic [31:0] value);
        if (send_gaps && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_opcode <= op;
        i_value  <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // rough fill level, used only to steer the stimulus
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (level_guess < DEPTH_DEF) level_guess++;
        end else if (op == OP_POP_SUM) begin
            level_guess = (level_guess >= 2) ? level_guess - 2 : 0;
        end
    endtask

    task automatic send_push(input logic [31:0] value);
        send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, value);
    endtask

    // Drop pop in random bursts while gaps are enabled
    task automatic drive_pop();
        int hold;
        hold = 0;
        forever begin
            if (hold == 0 && pop_gaps && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 14);
            pop <= (hold == 0);
            if (hold != 0) hold--;
            @(posedge i_clk);
        end
    endtask

    // Extremes, each operation, empty pop, single entry, unused opcode
    task automatic run_directed();
        send_op(OP_POP_SUM, W_NEG1);
        send_op(OP_UNUSED, W_MAX);
        send_op(OP_PUSH_BACK, W_MAX);
        send_op(OP_POP_SUM, '0);
        send_op(OP_PUSH_FRONT, W_MIN);
        send_op(OP_POP_SUM, '0);
        send_op(OP_PUSH_FRONT, W_MAX);
        send_op(OP_PUSH_BACK, W_MIN);
        send_op(OP_POP_SUM, '0);
        send_op(OP_PUSH_BACK, W_NEG1);
        send_op(OP_PUSH_FRONT, '0);
        send_op(OP_PUSH_BACK, 32'd1);
        send_op(OP_POP_SUM, '0);
        send_op(OP_POP_SUM, '0);
        send_op(OP_PUSH_FRONT, W_MAX);
        send_op(OP_PUSH_FRONT, W_MAX);
        send_op(OP_POP_SUM, '0);
        send_op(OP_PUSH_BACK, W_MIN);
        send_op(OP_PUSH_BACK, W_MIN);
        send_op(OP_POP_SUM, '0);
        send_op(OP_POP_SUM, W_NEG1);
        send_op(OP_UNUSED, '0);
    endtask

    // Random mix of operations with a little noise
    task automatic run_mix(input int items, input int pop_pct);
        int pick;
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_op(OP_UNUSED, $urandom);
            else if (pick < 5 + pop_pct)
                send_op(OP_POP_SUM, $urandom);
            else
                send_push(pick_word());
        end
    endtask

    // Push until the ring is full (wrapping both indexes), then push into a full ring
    task automatic run_fill();
        while (level_guess < DEPTH_DEF) begin
            if ($urandom_range(0, 99) < 3)
                send_op(OP_POP_SUM, $urandom);
            else
                send_push(pick_word());
        end
        repeat (FULL_EXTRA) send_push(pick_word());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_opcode    = OP_PUSH_FRONT;
        i_value     = '0;
        send_gaps   = 1'b1;
        pop_gaps    = 1'b1;
        level_guess = 0;
        idle_cycles = 0;
        board       = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drive_pop();
        join_none

        run_directed();
        run_mix(MIXED_ITEMS, 32);
        run_fill();
        // closing stretch: no gaps on either side, drain from full
        send_gaps = 1'b0;
        pop_gaps  = 1'b0;
        run_mix(CLOSING_ITEMS, 55);
        push <= 1'b0;

        // drain, then give stray results a chance to show up
        while (board.owed_count() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.close_out();

        $display("covered %0d operations: %0d sums, %0d empty pops, %0d full drops",
                 board.n_ops, board.n_sums, board.n_empty, board.n_full);
        $display("peak fill level %0d of %0d entries", board.peak, DEPTH_DEF);
        if (board.errors == 0) begin
            $display("deque_pop_both_sum_top test passed");
        end else begin
            $display("deque_pop_both_sum_top test failed");
        end
        $finish;
    end

endmodule

// File: deque_pop_both_sum_top.f
rtl/core/dpbs_pkg.sv
rtl/core/dpbs_front.sv
rtl/core/dpbs_cmdq.sv
rtl/core/dpbs_back.sv
rtl/core/deque_pop_both_sum_top.sv
verif/dpbs_sum_board_pkg.sv
verif/tb_deque_pop_both_sum_top.sv
